/* src/beam_matrix_to_midi_note_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the beam matrix to MIDI note block
// Shared property wrappers that report through $error.
// ----------------------------------------------------------------------------
`ifndef BEAM_MATRIX_TO_MIDI_NOTE_MACROS_SVH
`define BEAM_MATRIX_TO_MIDI_NOTE_MACROS_SVH

// A condition that must hold at every clock edge out of reset.
`define BMM_ASSERT_ALWAYS(label, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("bmm: invariant violated");

// A trigger that must be followed by a condition in the next cycle.
`define BMM_ASSERT_NEXT(label, trig, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
        else $error("bmm: sequence violated");

`endif

/* src/bmm_pkg.sv */
// ----------------------------------------------------------------------------
// bmm_pkg
// Types, constants and the note table for the beam matrix to MIDI note block.
// ----------------------------------------------------------------------------
package bmm_pkg;

    localparam int MAX_BEAMS = 8;

    localparam logic [3:0] IDX_NONE       = 4'hF;
    localparam logic [3:0] BEAMS_RESET    = 4'd8;
    localparam logic [7:0] STATUS_NOTE_ON = 8'h90;
    localparam logic [7:0] VEL_PRESS      = 8'd127;
    localparam logic [7:0] VEL_RELEASE    = 8'd0;
    localparam int         ROM_VALID_BIT  = 7;

    // Register word indexes on the configuration port.
    localparam logic REG_BEAMS_PER_AXIS = 1'b0;

    // Bit 7 marks a present entry; bits 6..0 hold the note. Index is {row, col}.
    localparam logic [7:0] NOTE_ROM [0:63] = '{
        8'd0,   8'd200, 8'd201, 8'd209, 8'd210, 8'd218, 8'd0,   8'd226,
        8'd188, 8'd189, 8'd202, 8'd203, 8'd211, 8'd0,   8'd219, 8'd220,
        8'd182, 8'd190, 8'd191, 8'd204, 8'd0,   8'd212, 8'd213, 8'd221,
        8'd183, 8'd184, 8'd192, 8'd0,   8'd205, 8'd206, 8'd214, 8'd215,
        8'd177, 8'd185, 8'd0,   8'd193, 8'd194, 8'd207, 8'd208, 8'd216,
        8'd178, 8'd0,   8'd186, 8'd187, 8'd195, 8'd196, 8'd209, 8'd210,
        8'd0,   8'd179, 8'd180, 8'd188, 8'd189, 8'd197, 8'd198, 8'd211,
        8'd172, 8'd173, 8'd181, 8'd182, 8'd190, 8'd191, 8'd199, 8'd0
    };

    // Release and press requests handed from the decoder to the byte emitter.
    typedef struct packed {
        logic       release_note;
        logic       press_note;
        logic [6:0] release_value;
        logic [6:0] press_value;
    } msg_t;

endpackage

/* src/bmm_scan_if.sv */
// ----------------------------------------------------------------------------
// bmm_scan_if
// Valid/ready channel that carries one beam sensor scan.
// ----------------------------------------------------------------------------
interface bmm_scan_if;
    logic        valid;
    logic        ready;
    logic [15:0] beam_mask;

    modport source (output valid, output beam_mask, input ready);
    modport sink (input valid, input beam_mask, output ready);
endinterface

/* src/bmm_midi_if.sv */
// ----------------------------------------------------------------------------
// bmm_midi_if
// Valid/ready channel that carries one MIDI byte and its end-of-scan flag.
// ----------------------------------------------------------------------------
interface bmm_midi_if;
    logic       valid;
    logic       ready;
    logic [7:0] midi_byte;
    logic       last_byte;

    modport source (output valid, output midi_byte, output last_byte, input ready);
    modport sink (input valid, input midi_byte, input last_byte, output ready);
endinterface

/* src/bmm_axis_pick.sv */
// ----------------------------------------------------------------------------
// bmm_axis_pick
// Selects the beam index of one axis from its lit beams and the held index.
// ----------------------------------------------------------------------------
module bmm_axis_pick (
    input  logic [7:0] axis,
    input  logic [3:0] size,
    input  logic [3:0] held,
    output logic [3:0] index
);

    logic       held_lit;
    logic [3:0] found;
    logic [3:0] count;

    // The axis bits above size are already masked off by the caller.
    always_comb
    begin
        found = bmm_pkg::IDX_NONE;
        count = 4'd0;
        for (int i = 0; i < bmm_pkg::MAX_BEAMS; i++)
        begin
            if (axis[3'(i)])
            begin
                found = 4'(i);
                count = count + 4'd1;
            end
        end
    end

    assign held_lit = (held < size) && axis[held[2:0]];

    always_comb
    begin
        if (held_lit)
            index = held;
        else if (count == 4'd1)
            index = found;
        else
            index = bmm_pkg::IDX_NONE;
    end

endmodule

/* src/bmm_emit.sv */
// ----------------------------------------------------------------------------
// bmm_emit
// Serializes the release and press messages of one scan into MIDI bytes.
// ----------------------------------------------------------------------------
module bmm_emit (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              load,
    input  bmm_pkg::msg_t     msg,
    output logic              free,
    bmm_midi_if.source        out
);

    logic          busy_reg;
    logic [2:0]    pos_reg;
    bmm_pkg::msg_t msg_reg;

    logic          in_release;
    logic [2:0]    last_pos;
    logic [2:0]    offset;
    logic          is_last;
    logic          out_done;

    // Release bytes come first when both messages are present.
    assign in_release = msg_reg.release_note && (pos_reg < 3'd3);
    assign offset     = (pos_reg >= 3'd3) ? pos_reg - 3'd3 : pos_reg;
    assign last_pos   = (msg_reg.release_note && msg_reg.press_note) ? 3'd5 : 3'd2;
    assign is_last    = (pos_reg == last_pos);
    assign out_done   = busy_reg && out.ready;
    assign free       = !busy_reg || (out_done && is_last);

    always_comb
    begin
        case (offset)
            3'd0:    out.midi_byte = bmm_pkg::STATUS_NOTE_ON;
            3'd1:    out.midi_byte = in_release ? {1'b0, msg_reg.release_value}
                                                : {1'b0, msg_reg.press_value};
            3'd2:    out.midi_byte = in_release ? bmm_pkg::VEL_RELEASE
                                                : bmm_pkg::VEL_PRESS;
            default: out.midi_byte = bmm_pkg::STATUS_NOTE_ON;
        endcase
    end

    assign out.valid     = busy_reg;
    assign out.last_byte = is_last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            pos_reg  <= 3'd0;
        end
        else if (load)
        begin
            busy_reg <= 1'b1;
            pos_reg  <= 3'd0;
        end
        else if (out_done)
        begin
            busy_reg <= !is_last;
            pos_reg  <= pos_reg + 3'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
            msg_reg <= msg;
    end

endmodule

/* src/beam_matrix_to_midi_note.sv */
// Latency: a scan is captured in the input register, decoded combinationally from it
// and loaded into the serializer register, which drives the first byte; bytes then
// leave one per cycle while midi.ready is high. Throughput: one scan per cycle when
// no bytes result; otherwise the next scan waits until the last byte is taken.
// Reset: held indexes return to none, no note sounds, beams_per_axis is 8.
// ----------------------------------------------------------------------------
// beam_matrix_to_midi_note
// Converts crossed-beam sensor scans into MIDI note-on and release bytes.
// ----------------------------------------------------------------------------
`include "beam_matrix_to_midi_note_macros.svh"

module beam_matrix_to_midi_note (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    bmm_scan_if.sink    scan,
    bmm_midi_if.source  midi
);

    logic [3:0]    beams_reg;
    logic          scan_valid_reg;
    logic [15:0]   mask_reg;
    logic [3:0]    held_x_reg;
    logic [3:0]    held_y_reg;
    logic          sounding_reg;
    logic [6:0]    note_reg;

    logic          cfg_write;
    logic [3:0]    size;
    logic [7:0]    field;
    logic [15:0]   y_shift;
    logic [7:0]    x_axis;
    logic [7:0]    y_axis;
    logic [3:0]    next_x;
    logic [3:0]    next_y;
    logic          changed;
    logic [2:0]    row;
    logic [2:0]    col;
    logic [7:0]    entry;
    logic          press;
    logic          emit_free;
    logic          advance;
    logic          load;
    bmm_pkg::msg_t msg;

    // Configuration port
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && (paddr[2] == bmm_pkg::REG_BEAMS_PER_AXIS);
    assign prdata    = (paddr[2] == bmm_pkg::REG_BEAMS_PER_AXIS) ? {28'd0, beams_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            beams_reg <= bmm_pkg::BEAMS_RESET;
        else if (cfg_write)
            beams_reg <= pwdata[3:0];
    end

    // Input register
    assign advance    = scan_valid_reg && emit_free;
    assign scan.ready = !scan_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            scan_valid_reg <= 1'b0;
        else if (scan.ready)
            scan_valid_reg <= scan.valid;
    end

    always_ff @(posedge clk)
    begin
        if (scan.valid && scan.ready)
            mask_reg <= scan.beam_mask;
    end

    // Decode
    always_comb
    begin
        if (beams_reg == 4'd0)
            size = 4'd1;
        else if (beams_reg > 4'(bmm_pkg::MAX_BEAMS))
            size = 4'(bmm_pkg::MAX_BEAMS);
        else
            size = beams_reg;
    end

    assign field   = 8'((9'd1 << size) - 9'd1);
    assign y_shift = mask_reg >> size;
    assign x_axis  = mask_reg[7:0] & field;
    assign y_axis  = y_shift[7:0] & field;

    bmm_axis_pick u_pick_x (
        .axis  (x_axis),
        .size  (size),
        .held  (held_x_reg),
        .index (next_x)
    );

    bmm_axis_pick u_pick_y (
        .axis  (y_axis),
        .size  (size),
        .held  (held_y_reg),
        .index (next_y)
    );

    assign changed = (next_x != held_x_reg) || (next_y != held_y_reg);

    // The table is laid out with the highest beam index first on both axes.
    assign row   = size[2:0] - 3'd1 - next_y[2:0];
    assign col   = size[2:0] - 3'd1 - next_x[2:0];
    assign entry = bmm_pkg::NOTE_ROM[{row, col}];
    assign press = (next_x != bmm_pkg::IDX_NONE) && (next_y != bmm_pkg::IDX_NONE)
                   && entry[bmm_pkg::ROM_VALID_BIT];

    assign msg.release_note  = sounding_reg;
    assign msg.press_note    = press;
    assign msg.release_value = note_reg;
    assign msg.press_value   = entry[6:0];

    assign load = advance && changed && (sounding_reg || press);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_x_reg   <= bmm_pkg::IDX_NONE;
            held_y_reg   <= bmm_pkg::IDX_NONE;
            sounding_reg <= 1'b0;
            note_reg     <= 7'd0;
        end
        else if (advance && changed)
        begin
            held_x_reg   <= next_x;
            held_y_reg   <= next_y;
            sounding_reg <= press;
            if (press)
                note_reg <= entry[6:0];
        end
    end

    bmm_emit u_emit (
        .clk   (clk),
        .rst_n (rst_n),
        .load  (load),
        .msg   (msg),
        .free  (emit_free),
        .out   (midi)
    );

    // A sounding note always belongs to a complete pair.
    `BMM_ASSERT_ALWAYS(a_sounding_pair,
        !sounding_reg || (held_x_reg != bmm_pkg::IDX_NONE && held_y_reg != bmm_pkg::IDX_NONE))
    // A transaction that is not the last byte is followed by more bytes.
    `BMM_ASSERT_NEXT(a_more_bytes, midi.valid && midi.ready && !midi.last_byte, midi.valid)
    // A held index is either none or inside the array.
    `BMM_ASSERT_ALWAYS(a_held_range,
        (held_x_reg == bmm_pkg::IDX_NONE || held_x_reg < 4'(bmm_pkg::MAX_BEAMS))
        && (held_y_reg == bmm_pkg::IDX_NONE || held_y_reg < 4'(bmm_pkg::MAX_BEAMS)))

endmodule
